>>> design/wfcol_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register map of the waveform column renderer.
package wfcol_pkg;

  localparam int DEF_SAMPLE_DEPTH = 4096;
  localparam int SAMPLE_W         = 16;
  localparam int STORE_W          = 2 * SAMPLE_W;
  localparam int COORD_W          = 13;
  localparam int BASE_W           = 28;
  localparam int PROD_W           = 44;
  localparam int PTR_W            = 13;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int EDGE_MARGIN      = 8;
  localparam int Q_HALF           = 16384;
  localparam int Q_SHIFT          = 15;
  localparam int CFG_ADDR_W       = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic [2:0] REG_SPF    = 3'd0;
  localparam logic [2:0] REG_FWIDTH = 3'd1;
  localparam logic [2:0] REG_FIRST  = 3'd2;
  localparam logic [2:0] REG_LEFT   = 3'd3;
  localparam logic [2:0] REG_TOP    = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_COUNT  = 3'd6;

  typedef enum logic {
    K_WRITE = 1'b0,
    K_DRAW  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              opcode;
    logic [11:0]       sample_index;
    logic signed [15:0] sample_min;
    logic signed [15:0] sample_max;
    logic [11:0]       column_offset;
  } in_item_t;

  typedef struct packed {
    logic [12:0] column_x;
    logic [12:0] line_top;
    logic [12:0] line_bottom;
  } out_item_t;

  typedef struct packed {
    logic [15:0] samples_per_frame;
    logic [11:0] frame_width;
    logic [15:0] first_frame;
    logic [11:0] area_left;
    logic [11:0] area_top;
    logic [11:0] area_height;
    logic [12:0] sample_count;
  } cfg_t;

  typedef struct packed {
    kind_t                kind;
    logic [11:0]          addr;
    logic signed [15:0]   smin;
    logic signed [15:0]   smax;
    logic [COORD_W-1:0]   column_x;
    logic [BASE_W-1:0]    base;
  } q_entry_t;

endpackage

>>> design/wfcol_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module wfcol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/wfcol_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue between the front end and the back end.
module wfcol_queue import wfcol_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty
);

  q_entry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/wfcol_front.sv
`timescale 1ns / 1ps
// Front end: takes commands, drops those without effect and forms queue entries.
module wfcol_front import wfcol_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     push,
  output q_entry_t push_data,
  input  logic     full
);

  logic     hold_valid_r, hold_valid_nxt;
  q_entry_t hold_r;
  q_entry_t entry;
  logic     accept;
  logic     keep;
  logic     wr_ok;
  logic     draw_ok;

  assign busy   = hold_valid_r && full;
  assign accept = start && !busy;
  assign push   = hold_valid_r && !full;

  always_comb begin
    wr_ok   = 32'(in_data.sample_index) < 32'(SAMPLE_DEPTH);
    draw_ok = (cfg.samples_per_frame != '0) && (cfg.frame_width != '0) &&
              (cfg.area_height != '0);
    keep    = (in_data.opcode == OP_WRITE) ? wr_ok : draw_ok;

    entry.kind     = (in_data.opcode == OP_WRITE) ? K_WRITE : K_DRAW;
    entry.addr     = in_data.sample_index;
    entry.smin     = in_data.sample_min;
    entry.smax     = in_data.sample_max;
    entry.column_x = COORD_W'(cfg.area_left) + COORD_W'(in_data.column_offset);
    entry.base     = BASE_W'(cfg.first_frame) * BASE_W'(cfg.frame_width) +
                     BASE_W'(in_data.column_offset);

    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = keep;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= entry;
    end
  end

  assign push_data = hold_r;

endmodule

>>> design/wfcol_back.sv
`timescale 1ns / 1ps
// Back end: sample writes, column range division, envelope scan and line scaling.
module wfcol_back import wfcol_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  q_entry_t  head,
  input  logic      empty,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W  = $clog2(PROD_W);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DINIT = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_RANGE = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_DRAIN = 9'b001000000,
    S_SCALE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [COORD_W-1:0]       colx_r, colx_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [PROD_W-1:0]        n0_r, n0_nxt, n1_r, n1_nxt;
  logic [11:0]              rem0_r, rem0_nxt, rem1_r, rem1_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [PTR_W-1:0]         ptr_r, ptr_nxt, end_r, end_nxt;
  logic                     rd_valid_r, rd_valid_nxt;
  logic signed [16:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [29:0]       plo_r, plo_nxt, phi_r, phi_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic                     ram_we, ram_re;
  logic [STORE_W-1:0]       ram_rdata;
  logic signed [15:0]       rd_min, rd_max;

  logic [12:0]              t0, t1;
  logic                     ge0, ge1;
  logic [PTR_W-1:0]         count;
  logic [PROD_W-1:0]        cnt_ext, last1, last2;
  logic [10:0]              half;
  logic [10:0]              amp;
  logic signed [12:0]       amp_s;
  logic [COORD_W-1:0]       centre;
  logic [COORD_W-1:0]       y_top, y_bot;

  function automatic logic [COORD_W-1:0] line_y(input logic signed [29:0] p,
                                                input logic [COORD_W-1:0] c);
    logic [29:0]        mag;
    logic [11:0]        r;
    logic signed [13:0] rs;
    logic signed [13:0] y;
    mag = p[29] ? 30'(-p) : 30'(p);
    r   = 12'((mag + 30'(Q_HALF)) >> Q_SHIFT);
    rs  = p[29] ? -14'(signed'({1'b0, r})) : 14'(signed'({1'b0, r}));
    y   = signed'({1'b0, c}) - rs;
    return y[13] ? '0 : y[COORD_W-1:0];
  endfunction

  assign rd_min = ram_rdata[SAMPLE_W-1:0];
  assign rd_max = ram_rdata[STORE_W-1:SAMPLE_W];

  wfcol_ram #(
    .WIDTH(STORE_W),
    .DEPTH(SAMPLE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(head.addr)),
    .wdata({head.smax, head.smin}),
    .re   (ram_re),
    .raddr(ADDR_W'(ptr_r)),
    .rdata(ram_rdata)
  );

  always_comb begin
    t0       = {rem0_r, n0_r[PROD_W-1]};
    t1       = {rem1_r, n1_r[PROD_W-1]};
    ge0      = t0 >= {1'b0, cfg.frame_width};
    ge1      = t1 >= {1'b0, cfg.frame_width};

    count    = (32'(cfg.sample_count) > 32'(SAMPLE_DEPTH)) ? PTR_W'(SAMPLE_DEPTH)
                                                           : cfg.sample_count;
    cnt_ext  = PROD_W'(count);
    last1    = (n1_r <= n0_r) ? n0_r + 1'b1 : n1_r;
    last2    = (last1 > cnt_ext) ? cnt_ext : last1;

    half     = cfg.area_height[11:1];
    amp      = (half > 11'(EDGE_MARGIN)) ? half - 11'(EDGE_MARGIN) : 11'd1;
    amp_s    = signed'({2'b00, amp});
    centre   = COORD_W'(cfg.area_top) + COORD_W'(half);
    y_top    = line_y(phi_r, centre);
    y_bot    = line_y(plo_r, centre);
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    colx_nxt      = colx_r;
    prod_nxt      = prod_r;
    n0_nxt        = n0_r;
    n1_nxt        = n1_r;
    rem0_nxt      = rem0_r;
    rem1_nxt      = rem1_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    rd_valid_nxt  = 1'b0;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (rd_valid_r) begin
      if (17'(rd_min) < lo_r) begin
        lo_nxt = 17'(rd_min);
      end
      if (17'(rd_max) > hi_r) begin
        hi_nxt = 17'(rd_max);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.kind == K_WRITE) begin
            ram_we = 1'b1;
          end else begin
            base_nxt  = head.base;
            colx_nxt  = head.column_x;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(base_r) * PROD_W'(cfg.samples_per_frame);
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        n0_nxt    = prod_r;
        n1_nxt    = prod_r + PROD_W'(cfg.samples_per_frame);
        rem0_nxt  = '0;
        rem1_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem0_nxt = ge0 ? 12'(t0 - {1'b0, cfg.frame_width}) : t0[11:0];
        rem1_nxt = ge1 ? 12'(t1 - {1'b0, cfg.frame_width}) : t1[11:0];
        n0_nxt   = {n0_r[PROD_W-2:0], ge0};
        n1_nxt   = {n1_r[PROD_W-2:0], ge1};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        ptr_nxt = n0_r[PTR_W-1:0];
        end_nxt = last2[PTR_W-1:0];
        lo_nxt  = 17'sd32768;
        hi_nxt  = -17'sd32768;
        if (n0_r >= cnt_ext) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re       = 1'b1;
        rd_valid_nxt = 1'b1;
        ptr_nxt      = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == end_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        plo_nxt   = 30'(lo_r) * 30'(amp_s);
        phi_nxt   = 30'(hi_r) * 30'(amp_s);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.column_x    = colx_r;
        out_nxt.line_top    = y_top;
        out_nxt.line_bottom = y_bot;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    colx_r <= colx_nxt;
    prod_r <= prod_nxt;
    n0_r   <= n0_nxt;
    n1_r   <= n1_nxt;
    rem0_r <= rem0_nxt;
    rem1_r <= rem1_nxt;
    ptr_r  <= ptr_nxt;
    end_r  <= end_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    out_r  <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule

>>> design/waveform_min_max_column_render.sv
`timescale 1ns / 1ps
// Top level of the min/max waveform column renderer with its register file.
// Usage: commands arrive on in_data and are taken when start is high and busy
// is low. A write command stores one (min,max) pair in the sample memory and
// gives no result. A draw command yields at most one vertical line, shown on
// out_data for a single cycle while out_strobe is high; the receiver cannot
// stall it. The user must write the registers over the APB-style port only
// while the block is idle; the block itself does not enforce this. pready
// is always high and reads return the stored values. The back end handles
// one write per cycle while no draw is running; a draw occupies it through
// the 44-step radix-2 range divider and one memory read per sample during
// the envelope scan. A four-entry queue between the command stage and the
// back end lets writes and draws be taken while a draw is running; busy
// rises only when that queue and the command stage are both full.
// Reset returns the registers to their defaults and empties the queue; the
// sample memory needs no clearing and holds unknown data until written.
module waveform_min_max_column_render import wfcol_pkg::*; #(
  parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [2:0] cfg_idx;
  logic       push, full, pop, empty;
  q_entry_t   push_data, head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_SPF:    cfg_nxt.samples_per_frame = pwdata[15:0];
        REG_FWIDTH: cfg_nxt.frame_width       = pwdata[11:0];
        REG_FIRST:  cfg_nxt.first_frame       = pwdata[15:0];
        REG_LEFT:   cfg_nxt.area_left         = pwdata[11:0];
        REG_TOP:    cfg_nxt.area_top          = pwdata[11:0];
        REG_HEIGHT: cfg_nxt.area_height       = pwdata[11:0];
        REG_COUNT:  cfg_nxt.sample_count      = pwdata[12:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SPF:    prdata = 32'(cfg_r.samples_per_frame);
      REG_FWIDTH: prdata = 32'(cfg_r.frame_width);
      REG_FIRST:  prdata = 32'(cfg_r.first_frame);
      REG_LEFT:   prdata = 32'(cfg_r.area_left);
      REG_TOP:    prdata = 32'(cfg_r.area_top);
      REG_HEIGHT: prdata = 32'(cfg_r.area_height);
      REG_COUNT:  prdata = 32'(cfg_r.sample_count);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_frame <= 16'd1;
      cfg_r.frame_width       <= 12'd1;
      cfg_r.first_frame       <= '0;
      cfg_r.area_left         <= '0;
      cfg_r.area_top          <= '0;
      cfg_r.area_height       <= 12'd1;
      cfg_r.sample_count      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wfcol_front #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .push_data(push_data),
    .full     (full)
  );

  wfcol_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  wfcol_back #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule
